// ----- sv/assert_macros.svh -----
// assertion macros used by quaternion_to_euler_angles.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QTE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QTE_ASSERT(lbl, prop, msg)
`define QTE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- sv/qte_pkg.sv -----
// types, constants and helpers for the quaternion to euler pipeline
package qte_pkg;

  localparam int SUM_W     = 35;   // exact sums scaled by 2^28
  localparam int CW        = 38;   // cordic x/y width
  localparam int ZW        = 34;   // cordic angle width, scaled by 2^30
  localparam int ISQ_W     = 58;   // square root remainder width
  localparam int ISQ_STEPS = 29;   // one result bit per stage
  localparam int TAB_LEN   = 24;

  localparam logic signed [ZW-1:0]    ANG_PI      = 34'sd3373259426;
  localparam logic signed [SUM_W-1:0] ONE_Q28     = 35'sd268435456;
  localparam logic signed [16:0]      OUT_PI      = 17'sd25736;
  localparam logic signed [16:0]      OUT_HALF_PI = 17'sd12868;

  localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  typedef struct packed {
    logic signed [SUM_W-1:0] sinr;
    logic signed [SUM_W-1:0] cosr;
    logic signed [SUM_W-1:0] siny;
    logic signed [SUM_W-1:0] cosy;
    logic signed [SUM_W-1:0] sinp;
  } arg_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } clamp_t;

  // round an angle at 2^30 to q3.13 and saturate
  function automatic logic signed [16:0] to_q13(input logic signed [ZW-1:0] a,
                                               input logic signed [16:0] lim);
    logic signed [ZW:0]    t;
    logic signed [ZW-17:0] r;
    logic signed [ZW-17:0] l;
    t = {a[ZW-1], a} + (ZW+1)'(65536);
    r = t[ZW:17];
    l = (ZW-16)'(lim);
    if (r > l) r = l;
    if (r < -l) r = -l;
    return r[16:0];
  endfunction

endpackage

// ----- sv/quaternion_to_euler_angles.sv -----
// quaternion to roll, pitch, yaw
// throughput one word per cycle; the whole pipeline holds while an output word waits
// the pipeline is made of the product/sum stages, the 29 square root stages, the cordic steps and the output stage
// rst_n synchronous active low clears the valid bits only; no state beyond the pipeline
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_angle, pitch_angle, yaw_angle, zero pad
  output logic [0:0]  out_tuser   // pitch_clamped
);

`include "assert_macros.svh"

  localparam int L    = 35 + CORDIC_STEPS;
  localparam int ISQ0 = 4;              // first square root stage
  localparam int CIN  = ISQ0 + ISQ_STEPS - 1;

  logic adv;
  logic [L-1:0] vld_r;

  assign adv        = !vld_r[L-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[L-2:0], in_tvalid};
  end

  // products
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = in_tdata[15:0];
  assign qx = in_tdata[31:16];
  assign qy = in_tdata[47:32];
  assign qz = in_tdata[63:48];

  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, zz_r, wy_r, zx_r, wz_r, xy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      wx_r <= qw * qx;  yz_r <= qy * qz;
      xx_r <= qx * qx;  yy_r <= qy * qy;  zz_r <= qz * qz;
      wy_r <= qw * qy;  zx_r <= qz * qx;
      wz_r <= qw * qz;  xy_r <= qx * qy;
    end
  end

  // sums, delayed to the cordic inputs
  arg_t   dl_r [1:CIN];
  clamp_t cl_r [1:L-2];
  arg_t   a_nxt;
  clamp_t c_nxt;

  always_comb begin
    a_nxt.sinr = (SUM_W'(wx_r) + SUM_W'(yz_r)) <<< 1;
    a_nxt.cosr = ONE_Q28 - ((SUM_W'(xx_r) + SUM_W'(yy_r)) <<< 1);
    a_nxt.sinp = (SUM_W'(wy_r) - SUM_W'(zx_r)) <<< 1;
    a_nxt.siny = (SUM_W'(wz_r) + SUM_W'(xy_r)) <<< 1;
    a_nxt.cosy = ONE_Q28 - ((SUM_W'(yy_r) + SUM_W'(zz_r)) <<< 1);
    c_nxt.pos  = a_nxt.sinp >= ONE_Q28;
    c_nxt.neg  = a_nxt.sinp <= -ONE_Q28;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[1] <= a_nxt;
      cl_r[1] <= c_nxt;
      for (int i = 2; i <= CIN; i++) dl_r[i] <= dl_r[i-1];
      for (int i = 2; i <= L-2; i++) cl_r[i] <= cl_r[i-1];
    end
  end

  // cos of pitch: sqrt(2^56 - sinp^2), meaningful only when not clamped
  logic signed [28:0]      sp;
  logic signed [57:0]      sq_r;
  logic        [ISQ_W-1:0] n_r   [ISQ0-1:CIN];
  logic        [ISQ_W-1:0] res_r [ISQ0-1:CIN];

  assign sp = dl_r[1].sinp[28:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r          <= sp * sp;
      n_r[ISQ0-1]   <= (ISQ_W'(1) << 56) - ISQ_W'(sq_r);
      res_r[ISQ0-1] <= '0;
    end
  end

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (56 - 2 * j);
    logic [ISQ_W-1:0] trial;
    assign trial = res_r[ISQ0-1+j] + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (n_r[ISQ0-1+j] >= trial) begin
          n_r[ISQ0+j]   <= n_r[ISQ0-1+j] - trial;
          res_r[ISQ0+j] <= (res_r[ISQ0-1+j] >> 1) + BIT;
        end else begin
          n_r[ISQ0+j]   <= n_r[ISQ0-1+j];
          res_r[ISQ0+j] <= res_r[ISQ0-1+j] >> 1;
        end
      end
    end
  end

  logic signed [SUM_W-1:0] cosp;
  assign cosp = SUM_W'({1'b0, res_r[CIN][28:0]});

  logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(adv), .in_y(dl_r[CIN].sinr), .in_x(dl_r[CIN].cosr), .out_z(roll_z)
  );
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(adv), .in_y(dl_r[CIN].sinp), .in_x(cosp), .out_z(pitch_z)
  );
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(adv), .in_y(dl_r[CIN].siny), .in_x(dl_r[CIN].cosy), .out_z(yaw_z)
  );

  // round, saturate, gimbal clamp
  logic signed [15:0] roll_r, yaw_r;
  logic signed [14:0] pitch_r;
  logic               clamped_r;
  logic signed [16:0] roll_q, yaw_q, pitch_q;

  always_comb begin
    roll_q = to_q13(roll_z, OUT_PI);
    yaw_q  = to_q13(yaw_z, OUT_PI);
    if (cl_r[L-2].pos)      pitch_q = OUT_HALF_PI;
    else if (cl_r[L-2].neg) pitch_q = -OUT_HALF_PI;
    else                    pitch_q = to_q13(pitch_z, OUT_HALF_PI);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r    <= roll_q[15:0];
      yaw_r     <= yaw_q[15:0];
      pitch_r   <= pitch_q[14:0];
      clamped_r <= cl_r[L-2].pos | cl_r[L-2].neg;
    end
  end

  assign out_tdata = {1'b0, yaw_r, pitch_r, roll_r};
  assign out_tuser = clamped_r;

  `QTE_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "output valid right after reset")
  `QTE_ASSERT(a_stall_hold, !adv |=> $stable(vld_r), "valid bits moved during a stall")
  `QTE_ASSERT(a_clamp_val, (out_tvalid && clamped_r) |-> (pitch_r == 15'sd12868 || pitch_r == -15'sd12868), "clamped pitch not at half pi")
  `QTE_ASSERT(a_roll_rng, out_tvalid |-> (roll_r <= 16'sd25736 && roll_r >= -16'sd25736), "roll beyond pi")

endmodule

// ----- sv/qte_cordic.sv -----
// pipelined vectoring cordic atan2, one stage per step
module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [SUM_W-1:0] in_y,
  input  logic signed [SUM_W-1:0] in_x,
  output logic signed [ZW-1:0]    out_z
);

  logic signed [CW-1:0] x_r [STEPS+1];
  logic signed [CW-1:0] y_r [STEPS+1];
  logic signed [ZW-1:0] z_r [STEPS+1];
  logic                 zero_r [STEPS+1];

  logic signed [CW-1:0] xe, ye;
  assign xe = CW'(in_x);
  assign ye = CW'(in_y);

  // left half plane reflected, offset by plus or minus pi
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        z_r[0] <= (in_y >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [CW-1:0] xs, ys;
    assign xs = x_r[k] >>> k;
    assign ys = y_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[k+1] <= zero_r[k];
        if (y_r[k] >= 0) begin
          x_r[k+1] <= x_r[k] + ys;
          y_r[k+1] <= y_r[k] - xs;
          z_r[k+1] <= z_r[k] + ATAN_TAB[k];
        end else begin
          x_r[k+1] <= x_r[k] - ys;
          y_r[k+1] <= y_r[k] + xs;
          z_r[k+1] <= z_r[k] - ATAN_TAB[k];
        end
      end
    end
  end

  assign out_z = zero_r[STEPS] ? '0 : z_r[STEPS];

endmodule
